>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertions with the common reset qualifier.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// assert that an antecedent implies a consequent on the same edge
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> rtl/ibhpq_pkg.sv
// ---------------------------------------------------------------------------
// ibhpq_pkg
// Types, constants and helpers of the indexed binary heap priority queue.
// ---------------------------------------------------------------------------
package ibhpq_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W    = 8;
	localparam int CNT_W    = 9;
	localparam int PRI_W    = 64;
	localparam int PAY_W    = 32;
	localparam int IN_W     = 104;
	localparam int OUT_W    = 88;
	localparam int OUT_USED = 82;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PRI_W-1:0] pri_t;
	typedef logic [PAY_W-1:0] pay_t;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_CHANGE = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_HANDLE = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_FAIL_FULL,
		CMD_FAIL_EMPTY,
		CMD_FAIL_HANDLE,
		CMD_PUSH_FREE_RD,
		CMD_PUSH_WR,
		CMD_SU_RD,
		CMD_SU_RD2,
		CMD_SU_MOVE,
		CMD_SD_RD,
		CMD_SD_RD2,
		CMD_SD_MOVE,
		CMD_PLACE,
		CMD_POP_RD,
		CMD_POP_RD2,
		CMD_POP_REL,
		CMD_CH_RD,
		CMD_CH_WR,
		CMD_RM_RD,
		CMD_RM_RD2,
		CMD_RM_REL,
		CMD_TOP_RD,
		CMD_TOP_RD2,
		CMD_TOP_SET,
		CMD_LOAD_OUT
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECIDE,
		S_PUSH_WR,
		S_SU_CHK,
		S_SU_RD2,
		S_SU_CMP,
		S_SD_CHK,
		S_SD_RD2,
		S_SD_CMP,
		S_POP_RD2,
		S_POP_REL,
		S_CH_WR,
		S_RM_RD2,
		S_RM_REL,
		S_TOP_RD,
		S_TOP_RD2,
		S_TOP_SET,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t  op;
		logic push_full;
		logic have_free;
		logic cnt_zero;
		logic hin_bad;
		logic su_root;
		logic su_move;
		logic sd_leaf;
		logic sd_move;
		logic ch_up;
		logic rm_stay;
		logic rm_up;
		logic out_free;
	} dp_status_t;

	// true when priority a must sit strictly above priority b
	function automatic logic outranks(input logic order, input pri_t a, input pri_t b);
		return order ? (a > b) : (a < b);
	endfunction

endpackage

>>> rtl/ibhpq_ctrl.sv
// ---------------------------------------------------------------------------
// ibhpq_ctrl
// Sequencer of the heap operations; at most one datapath command per cycle.
// ---------------------------------------------------------------------------
module ibhpq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  ibhpq_pkg::dp_status_t  st,
	output ibhpq_pkg::cmd_t        cmd
);

	ibhpq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibhpq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ibhpq_pkg::S_IDLE: begin
				if (s_tvalid) state_d = ibhpq_pkg::S_DECIDE;
			end
			ibhpq_pkg::S_DECIDE: begin
				case (st.op)
					ibhpq_pkg::OP_PUSH:
						state_d = st.push_full ? ibhpq_pkg::S_DONE : ibhpq_pkg::S_PUSH_WR;
					ibhpq_pkg::OP_POP:
						state_d = st.cnt_zero ? ibhpq_pkg::S_DONE : ibhpq_pkg::S_POP_RD2;
					ibhpq_pkg::OP_CHANGE:
						state_d = st.hin_bad ? ibhpq_pkg::S_DONE : ibhpq_pkg::S_CH_WR;
					default:
						state_d = st.hin_bad ? ibhpq_pkg::S_DONE : ibhpq_pkg::S_RM_RD2;
				endcase
			end
			ibhpq_pkg::S_PUSH_WR: state_d = ibhpq_pkg::S_SU_CHK;
			ibhpq_pkg::S_SU_CHK:
				state_d = st.su_root ? ibhpq_pkg::S_TOP_RD : ibhpq_pkg::S_SU_RD2;
			ibhpq_pkg::S_SU_RD2: state_d = ibhpq_pkg::S_SU_CMP;
			ibhpq_pkg::S_SU_CMP:
				state_d = st.su_move ? ibhpq_pkg::S_SU_CHK : ibhpq_pkg::S_TOP_RD;
			ibhpq_pkg::S_SD_CHK:
				state_d = st.sd_leaf ? ibhpq_pkg::S_TOP_RD : ibhpq_pkg::S_SD_RD2;
			ibhpq_pkg::S_SD_RD2: state_d = ibhpq_pkg::S_SD_CMP;
			ibhpq_pkg::S_SD_CMP:
				state_d = st.sd_move ? ibhpq_pkg::S_SD_CHK : ibhpq_pkg::S_TOP_RD;
			ibhpq_pkg::S_POP_RD2: state_d = ibhpq_pkg::S_POP_REL;
			ibhpq_pkg::S_POP_REL:
				state_d = st.cnt_zero ? ibhpq_pkg::S_TOP_RD : ibhpq_pkg::S_SD_CHK;
			ibhpq_pkg::S_CH_WR:
				state_d = st.ch_up ? ibhpq_pkg::S_SU_CHK : ibhpq_pkg::S_SD_CHK;
			ibhpq_pkg::S_RM_RD2: state_d = ibhpq_pkg::S_RM_REL;
			ibhpq_pkg::S_RM_REL: begin
				if (st.rm_stay) state_d = ibhpq_pkg::S_TOP_RD;
				else if (st.rm_up) state_d = ibhpq_pkg::S_SU_CHK;
				else state_d = ibhpq_pkg::S_SD_CHK;
			end
			ibhpq_pkg::S_TOP_RD:  state_d = ibhpq_pkg::S_TOP_RD2;
			ibhpq_pkg::S_TOP_RD2: state_d = ibhpq_pkg::S_TOP_SET;
			ibhpq_pkg::S_TOP_SET: state_d = ibhpq_pkg::S_DONE;
			ibhpq_pkg::S_DONE: begin
				if (st.out_free) state_d = ibhpq_pkg::S_IDLE;
			end
			default: state_d = ibhpq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = ibhpq_pkg::CMD_NONE;
		s_tready = 1'b0;
		case (state_q)
			ibhpq_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) cmd = ibhpq_pkg::CMD_LATCH;
			end
			ibhpq_pkg::S_DECIDE: begin
				case (st.op)
					ibhpq_pkg::OP_PUSH: begin
						if (st.push_full) cmd = ibhpq_pkg::CMD_FAIL_FULL;
						else if (st.have_free) cmd = ibhpq_pkg::CMD_PUSH_FREE_RD;
					end
					ibhpq_pkg::OP_POP:
						cmd = st.cnt_zero ? ibhpq_pkg::CMD_FAIL_EMPTY : ibhpq_pkg::CMD_POP_RD;
					ibhpq_pkg::OP_CHANGE:
						cmd = st.hin_bad ? ibhpq_pkg::CMD_FAIL_HANDLE : ibhpq_pkg::CMD_CH_RD;
					default:
						cmd = st.hin_bad ? ibhpq_pkg::CMD_FAIL_HANDLE : ibhpq_pkg::CMD_RM_RD;
				endcase
			end
			ibhpq_pkg::S_PUSH_WR: cmd = ibhpq_pkg::CMD_PUSH_WR;
			ibhpq_pkg::S_SU_CHK:
				cmd = st.su_root ? ibhpq_pkg::CMD_PLACE : ibhpq_pkg::CMD_SU_RD;
			ibhpq_pkg::S_SU_RD2: cmd = ibhpq_pkg::CMD_SU_RD2;
			ibhpq_pkg::S_SU_CMP:
				cmd = st.su_move ? ibhpq_pkg::CMD_SU_MOVE : ibhpq_pkg::CMD_PLACE;
			ibhpq_pkg::S_SD_CHK:
				cmd = st.sd_leaf ? ibhpq_pkg::CMD_PLACE : ibhpq_pkg::CMD_SD_RD;
			ibhpq_pkg::S_SD_RD2: cmd = ibhpq_pkg::CMD_SD_RD2;
			ibhpq_pkg::S_SD_CMP:
				cmd = st.sd_move ? ibhpq_pkg::CMD_SD_MOVE : ibhpq_pkg::CMD_PLACE;
			ibhpq_pkg::S_POP_RD2: cmd = ibhpq_pkg::CMD_POP_RD2;
			ibhpq_pkg::S_POP_REL: cmd = ibhpq_pkg::CMD_POP_REL;
			ibhpq_pkg::S_CH_WR:   cmd = ibhpq_pkg::CMD_CH_WR;
			ibhpq_pkg::S_RM_RD2:  cmd = ibhpq_pkg::CMD_RM_RD2;
			ibhpq_pkg::S_RM_REL:  cmd = ibhpq_pkg::CMD_RM_REL;
			ibhpq_pkg::S_TOP_RD:  cmd = ibhpq_pkg::CMD_TOP_RD;
			ibhpq_pkg::S_TOP_RD2: cmd = ibhpq_pkg::CMD_TOP_RD2;
			ibhpq_pkg::S_TOP_SET: cmd = ibhpq_pkg::CMD_TOP_SET;
			ibhpq_pkg::S_DONE: begin
				if (st.out_free) cmd = ibhpq_pkg::CMD_LOAD_OUT;
			end
			default: cmd = ibhpq_pkg::CMD_NONE;
		endcase
	end

endmodule

>>> rtl/ibhpq_dp.sv
// ---------------------------------------------------------------------------
// ibhpq_dp
// Heap memories, handle bookkeeping, compare logic and result register.
// ---------------------------------------------------------------------------
module ibhpq_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ibhpq_pkg::cmd_t               cmd,
	output ibhpq_pkg::dp_status_t         st,
	input  logic [ibhpq_pkg::IN_W-1:0]    s_tdata,
	input  logic [1:0]                    s_tuser,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ibhpq_pkg::OUT_W-1:0]   m_tdata,
	output logic [1:0]                    m_tuser
);

	localparam int PAD_W = ibhpq_pkg::OUT_W - ibhpq_pkg::OUT_USED;

	// memories
	ibhpq_pkg::idx_t slot_mem [ibhpq_pkg::CAPACITY];
	ibhpq_pkg::pri_t pri_mem  [ibhpq_pkg::CAPACITY];
	ibhpq_pkg::pay_t pay_mem  [ibhpq_pkg::CAPACITY];
	ibhpq_pkg::idx_t posn_mem [ibhpq_pkg::CAPACITY];
	ibhpq_pkg::idx_t free_mem [ibhpq_pkg::CAPACITY];

	ibhpq_pkg::idx_t slot_ra0, slot_ra1, slot_wa, slot_wd, slot_rd0, slot_rd1;
	logic            slot_re, slot_we;
	ibhpq_pkg::idx_t pri_ra0, pri_ra1, pri_wa;
	ibhpq_pkg::pri_t pri_wd, pri_rd0, pri_rd1;
	logic            pri_re, pri_we;
	ibhpq_pkg::idx_t pay_ra, pay_wa;
	ibhpq_pkg::pay_t pay_wd, pay_rd;
	logic            pay_re, pay_we;
	ibhpq_pkg::idx_t posn_ra, posn_wa, posn_wd, posn_rd;
	logic            posn_re, posn_we;
	ibhpq_pkg::idx_t free_ra, free_wa, free_wd, free_rd;
	logic            free_re, free_we;

	// working registers
	ibhpq_pkg::op_t     op_q;
	ibhpq_pkg::pri_t    pri_in_q, p_q, old_q;
	ibhpq_pkg::pay_t    pay_in_q, popped_q, top_pay_q;
	ibhpq_pkg::idx_t    hin_q, h_q, pos_q, newh_q;
	ibhpq_pkg::cnt_t    cnt_q, fdepth_q, fresh_q;
	ibhpq_pkg::status_t status_q;
	logic               order_q, from_free_q;
	logic [ibhpq_pkg::CAPACITY-1:0] inuse_q;

	// result register
	ibhpq_pkg::status_t out_status_q;
	ibhpq_pkg::idx_t    out_newh_q;
	ibhpq_pkg::pay_t    out_pop_q, out_topp_q;
	ibhpq_pkg::cnt_t    out_cnt_q;
	logic               out_topv_q, out_valid_q;

	// derived values
	ibhpq_pkg::idx_t         up_idx, push_h, sd_h;
	ibhpq_pkg::cnt_t         c0;
	logic [ibhpq_pkg::CNT_W:0] c1;
	ibhpq_pkg::cnt_t         sd_c;
	ibhpq_pkg::pri_t         sd_pri;
	logic                    sd_sel, do_release;

	assign up_idx = ibhpq_pkg::idx_t'((pos_q - ibhpq_pkg::idx_t'(1)) >> 1);
	assign c0     = {pos_q, 1'b1};
	assign c1     = {1'b0, pos_q, 1'b0} + (ibhpq_pkg::CNT_W+1)'(2);
	assign sd_sel = ({1'b0, cnt_q} > c1) && ibhpq_pkg::outranks(order_q, pri_rd1, pri_rd0);
	assign sd_pri = sd_sel ? pri_rd1 : pri_rd0;
	assign sd_h   = sd_sel ? slot_rd1 : slot_rd0;
	assign sd_c   = sd_sel ? c1[ibhpq_pkg::CNT_W-1:0] : c0;
	assign push_h = from_free_q ? free_rd : fresh_q[ibhpq_pkg::IDX_W-1:0];
	assign do_release = (cmd == ibhpq_pkg::CMD_POP_REL) || (cmd == ibhpq_pkg::CMD_RM_REL);

	assign st.op        = op_q;
	assign st.push_full = (cnt_q == ibhpq_pkg::cnt_t'(ibhpq_pkg::CAPACITY)) ||
		((fdepth_q == '0) && (fresh_q >= ibhpq_pkg::cnt_t'(ibhpq_pkg::CAPACITY)));
	assign st.have_free = (fdepth_q != '0);
	assign st.cnt_zero  = (cnt_q == '0);
	assign st.hin_bad   = !inuse_q[hin_q];
	assign st.su_root   = (pos_q == '0);
	assign st.su_move   = ibhpq_pkg::outranks(order_q, p_q, pri_rd0);
	assign st.sd_leaf   = (c0 >= cnt_q);
	assign st.sd_move   = ibhpq_pkg::outranks(order_q, sd_pri, p_q);
	assign st.ch_up     = ibhpq_pkg::outranks(order_q, pri_in_q, pri_rd0);
	assign st.rm_stay   = ({1'b0, pos_q} >= cnt_q);
	assign st.rm_up     = ibhpq_pkg::outranks(order_q, pri_rd0, old_q);
	assign st.out_free  = !out_valid_q || m_tready;

	// memory addressing
	always_comb begin
		slot_re = 1'b0; slot_ra0 = '0; slot_ra1 = '0;
		slot_we = 1'b0; slot_wa = pos_q; slot_wd = h_q;
		pri_re = 1'b0; pri_ra0 = '0; pri_ra1 = '0;
		pri_we = 1'b0; pri_wa = hin_q; pri_wd = pri_in_q;
		pay_re = 1'b0; pay_ra = '0;
		pay_we = 1'b0; pay_wa = push_h; pay_wd = pay_in_q;
		posn_re = 1'b0; posn_ra = hin_q;
		posn_we = 1'b0; posn_wa = h_q; posn_wd = pos_q;
		free_re = 1'b0; free_ra = ibhpq_pkg::idx_t'(fdepth_q - ibhpq_pkg::cnt_t'(1));
		free_we = 1'b0; free_wa = fdepth_q[ibhpq_pkg::IDX_W-1:0]; free_wd = hin_q;
		case (cmd)
			ibhpq_pkg::CMD_PUSH_FREE_RD: free_re = 1'b1;
			ibhpq_pkg::CMD_PUSH_WR: begin
				pri_we = 1'b1; pri_wa = push_h;
				pay_we = 1'b1;
			end
			ibhpq_pkg::CMD_SU_RD: begin
				slot_re = 1'b1; slot_ra0 = up_idx;
			end
			ibhpq_pkg::CMD_SU_RD2: begin
				pri_re = 1'b1; pri_ra0 = slot_rd0;
			end
			ibhpq_pkg::CMD_SU_MOVE: begin
				slot_we = 1'b1; slot_wd = slot_rd0;
				posn_we = 1'b1; posn_wa = slot_rd0;
			end
			ibhpq_pkg::CMD_SD_RD: begin
				slot_re  = 1'b1;
				slot_ra0 = c0[ibhpq_pkg::IDX_W-1:0];
				slot_ra1 = c1[ibhpq_pkg::IDX_W-1:0];
			end
			ibhpq_pkg::CMD_SD_RD2: begin
				pri_re = 1'b1; pri_ra0 = slot_rd0; pri_ra1 = slot_rd1;
			end
			ibhpq_pkg::CMD_SD_MOVE: begin
				slot_we = 1'b1; slot_wd = sd_h;
				posn_we = 1'b1; posn_wa = sd_h;
			end
			ibhpq_pkg::CMD_PLACE: begin
				slot_we = 1'b1;
				posn_we = 1'b1;
			end
			ibhpq_pkg::CMD_POP_RD: begin
				slot_re  = 1'b1;
				slot_ra1 = ibhpq_pkg::idx_t'(cnt_q - ibhpq_pkg::cnt_t'(1));
			end
			ibhpq_pkg::CMD_POP_RD2: begin
				pay_re = 1'b1; pay_ra = slot_rd0;
				pri_re = 1'b1; pri_ra0 = slot_rd1;
			end
			ibhpq_pkg::CMD_CH_RD, ibhpq_pkg::CMD_RM_RD: begin
				pri_re  = 1'b1; pri_ra0 = hin_q;
				posn_re = 1'b1;
				if (cmd == ibhpq_pkg::CMD_RM_RD) begin
					slot_re  = 1'b1;
					slot_ra1 = ibhpq_pkg::idx_t'(cnt_q - ibhpq_pkg::cnt_t'(1));
				end
			end
			ibhpq_pkg::CMD_CH_WR: pri_we = 1'b1;
			ibhpq_pkg::CMD_RM_RD2: begin
				pri_re = 1'b1; pri_ra0 = slot_rd1;
			end
			ibhpq_pkg::CMD_TOP_RD: slot_re = 1'b1;
			ibhpq_pkg::CMD_TOP_RD2: begin
				pay_re = 1'b1; pay_ra = slot_rd0;
			end
			default: slot_re = 1'b0;
		endcase
		if (do_release && (fdepth_q < ibhpq_pkg::cnt_t'(ibhpq_pkg::CAPACITY))) begin
			free_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		if (slot_re) begin
			slot_rd0 <= slot_mem[slot_ra0];
			slot_rd1 <= slot_mem[slot_ra1];
		end
		if (pri_we) pri_mem[pri_wa] <= pri_wd;
		if (pri_re) begin
			pri_rd0 <= pri_mem[pri_ra0];
			pri_rd1 <= pri_mem[pri_ra1];
		end
		if (pay_we) pay_mem[pay_wa] <= pay_wd;
		if (pay_re) pay_rd <= pay_mem[pay_ra];
		if (posn_we) posn_mem[posn_wa] <= posn_wd;
		if (posn_re) posn_rd <= posn_mem[posn_ra];
		if (free_we) free_mem[free_wa] <= free_wd;
		if (free_re) free_rd <= free_mem[free_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q     <= 1'b0;
			cnt_q       <= '0;
			fdepth_q    <= '0;
			fresh_q     <= '0;
			inuse_q     <= '0;
			from_free_q <= 1'b0;
			top_pay_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) order_q <= cfg_wdata;
			if (cmd == ibhpq_pkg::CMD_LOAD_OUT) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (cmd)
				ibhpq_pkg::CMD_LATCH: from_free_q <= 1'b0;
				ibhpq_pkg::CMD_PUSH_FREE_RD: begin
					from_free_q <= 1'b1;
					fdepth_q    <= fdepth_q - ibhpq_pkg::cnt_t'(1);
				end
				ibhpq_pkg::CMD_PUSH_WR: begin
					inuse_q[push_h] <= 1'b1;
					cnt_q           <= cnt_q + ibhpq_pkg::cnt_t'(1);
					if (!from_free_q) fresh_q <= fresh_q + ibhpq_pkg::cnt_t'(1);
				end
				ibhpq_pkg::CMD_POP_RD, ibhpq_pkg::CMD_RM_RD:
					cnt_q <= cnt_q - ibhpq_pkg::cnt_t'(1);
				ibhpq_pkg::CMD_TOP_SET: top_pay_q <= (cnt_q != '0) ? pay_rd : '0;
				default: from_free_q <= from_free_q;
			endcase
			if (do_release) begin
				inuse_q[hin_q] <= 1'b0;
				if (free_we) fdepth_q <= fdepth_q + ibhpq_pkg::cnt_t'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd)
			ibhpq_pkg::CMD_LATCH: begin
				op_q     <= ibhpq_pkg::op_t'(s_tuser);
				pri_in_q <= s_tdata[63:0];
				pay_in_q <= s_tdata[95:64];
				hin_q    <= s_tdata[103:96];
				status_q <= ibhpq_pkg::ST_OK;
				newh_q   <= '0;
				popped_q <= '0;
			end
			ibhpq_pkg::CMD_FAIL_FULL:   status_q <= ibhpq_pkg::ST_FULL;
			ibhpq_pkg::CMD_FAIL_EMPTY:  status_q <= ibhpq_pkg::ST_EMPTY;
			ibhpq_pkg::CMD_FAIL_HANDLE: status_q <= ibhpq_pkg::ST_HANDLE;
			ibhpq_pkg::CMD_PUSH_WR: begin
				h_q    <= push_h;
				p_q    <= pri_in_q;
				pos_q  <= cnt_q[ibhpq_pkg::IDX_W-1:0];
				newh_q <= push_h;
			end
			ibhpq_pkg::CMD_SU_MOVE: pos_q <= up_idx;
			ibhpq_pkg::CMD_SD_MOVE: pos_q <= sd_c[ibhpq_pkg::IDX_W-1:0];
			ibhpq_pkg::CMD_POP_RD2: begin
				h_q   <= slot_rd1;
				hin_q <= slot_rd0;
			end
			ibhpq_pkg::CMD_POP_REL: begin
				popped_q <= pay_rd;
				p_q      <= pri_rd0;
				pos_q    <= '0;
			end
			ibhpq_pkg::CMD_CH_WR: begin
				h_q   <= hin_q;
				p_q   <= pri_in_q;
				pos_q <= posn_rd;
			end
			ibhpq_pkg::CMD_RM_RD2: begin
				old_q <= pri_rd0;
				pos_q <= posn_rd;
				h_q   <= slot_rd1;
			end
			ibhpq_pkg::CMD_RM_REL: p_q <= pri_rd0;
			ibhpq_pkg::CMD_LOAD_OUT: begin
				out_status_q <= status_q;
				out_newh_q   <= newh_q;
				out_pop_q    <= popped_q;
				out_cnt_q    <= cnt_q;
				out_topv_q   <= (cnt_q != '0);
				out_topp_q   <= top_pay_q;
			end
			default: op_q <= op_q;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_topp_q, out_topv_q, out_cnt_q, out_pop_q, out_newh_q};

endmodule

>>> rtl/indexed_binary_heap_priority_queue_top.sv
// A failed operation ends after its decision; a sift step per tree level is a slot read, a
// priority read and a compare, over at most 8 levels.
// One word is handled at a time; the next input word is taken once the result is registered,
// while that result waits on the output.
// Reset: asynchronous, active low; empties the queue and sets smallest-on-top order.
// ---------------------------------------------------------------------------
// indexed_binary_heap_priority_queue_top
// Min or max heap with stable handles: push, pop, change priority, remove.
// ---------------------------------------------------------------------------
module indexed_binary_heap_priority_queue_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [ibhpq_pkg::IN_W-1:0]  s_tdata,   // priority_req, payload, handle
	input  logic [1:0]                  s_tuser,   // operation
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [ibhpq_pkg::OUT_W-1:0] m_tdata,   // new_handle, popped_payload,
	                                               // entry_count, top_valid, top_payload
	output logic [1:0]                  m_tuser,   // status
	input  logic                        cfg_we,
	input  logic                        cfg_wdata  // heap_order
);

	ibhpq_pkg::cmd_t       cmd;
	ibhpq_pkg::dp_status_t st;

	ibhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ibhpq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> rtl/ibhpq_checker.sv
// ---------------------------------------------------------------------------
// ibhpq_checker
// Port-level checks of the result stream and of input acceptance.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ibhpq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [ibhpq_pkg::OUT_W-1:0] m_tdata,
	input logic [1:0]                  m_tuser
);

	`ASSERT_IMPL(a_top_valid, m_tvalid, m_tdata[49] == (m_tdata[48:40] != 9'd0), "top_valid disagrees with count")
	`ASSERT_IMPL(a_count_max, m_tvalid, m_tdata[48:40] <= 9'(ibhpq_pkg::CAPACITY), "count above capacity")
	`ASSERT_IMPL(a_fail_clean, m_tvalid && (m_tuser != ibhpq_pkg::ST_OK), m_tdata[39:0] == 40'd0, "failed word carries data")
	`ASSERT_CLK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result dropped while stalled")
	`ASSERT_CLK(a_one_word, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

endmodule

bind indexed_binary_heap_priority_queue_top ibhpq_checker u_chk (.*);
